### src/tfg_pkg.sv
// ----------------------------------------------------------------------------
// tfg_pkg: shared types and codes of the teleoperation frame gate
//
// Opcode, frame action and button action codes, and the structs that carry
// one decoded input item and one result between the top level and the core.
// ----------------------------------------------------------------------------
package tfg_pkg;

    // Opcodes carried in the input tuser
    localparam logic [2:0] OP_SET_ENABLE = 3'd0;
    localparam logic [2:0] OP_BUTTON     = 3'd1;
    localparam logic [2:0] OP_CLASSIFY   = 3'd2;
    localparam logic [2:0] OP_COMMIT     = 3'd3;
    localparam logic [2:0] OP_FRESHNESS  = 3'd4;

    // Frame classification results
    localparam logic [2:0] FA_IGNORE_DISABLED = 3'd0;
    localparam logic [2:0] FA_IGNORE_STALE    = 3'd1;
    localparam logic [2:0] FA_IGNORE_APPLIED  = 3'd2;
    localparam logic [2:0] FA_RESET_APPLY     = 3'd3;
    localparam logic [2:0] FA_APPLY           = 3'd4;

    // Button results
    localparam logic [1:0] BA_NONE   = 2'd0;
    localparam logic [1:0] BA_PAUSE  = 2'd1;
    localparam logic [1:0] BA_RESUME = 2'd2;

    localparam int unsigned TDATA_IN_BITS  = 232;
    localparam int unsigned TDATA_OUT_BITS = 72;

    typedef struct packed {
        logic [2:0]  opcode;
        logic        enable_value;
        logic [31:0] frame_epoch;
        logic [31:0] frame_sequence;
        logic [31:0] resync_generation;
        logic        discontinuity;
        logic        button_pressed;
        logic [63:0] receive_ns;
        logic [63:0] now_ns;
    } t_item;

    typedef struct packed {
        logic [2:0]  frame_action;
        logic [1:0]  button_action;
        logic [62:0] age_ns;
        logic        has_applied;
        logic        is_stale;
        logic        is_live;
        logic        is_enabled;
    } t_result;

endpackage

### src/teleop_frame_gate_top.sv
// ----------------------------------------------------------------------------
// teleop_frame_gate_top: stream gate for teleoperation frames
//
// Accepts one item per clock while the result stream is not stalled and
// returns exactly one result per item, through the input register and then
// the result register. The rate of one item per cycle is set by the state
// update in the core: each item sees the state left by the one before it.
// The timeout register is written over its own valid/ready channel, which
// is always ready; write it only while no transaction is in flight.
// ----------------------------------------------------------------------------
module teleop_frame_gate_top #(
    parameter int unsigned COUNTER_BITS = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // Input stream
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata: enable_value[0], frame_epoch[32:1], frame_sequence[64:33],
    //        resync_generation[96:65], discontinuity[97], button_pressed[98],
    //        receive_ns[162:99], now_ns[226:163], zero fill[231:227]
    input  logic [tfg_pkg::TDATA_IN_BITS-1:0] s_axis_tdata,
    // tuser: opcode[2:0]
    input  logic [2:0]   s_axis_tuser,
    // Result stream
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata: frame_action[2:0], button_action[4:3], age_ns[67:5],
    //        has_applied[68], is_stale[69], is_live[70], is_enabled[71]
    output logic [tfg_pkg::TDATA_OUT_BITS-1:0] m_axis_tdata,
    // Timeout register write channel
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [62:0]  i_cfg_data
);
    import tfg_pkg::*;

    localparam logic [62:0] TIMEOUT_RESET = 63'd500000000;

    t_item       r_in;
    logic        r_in_valid;
    t_result     r_out;
    logic        r_out_valid;
    logic [62:0] r_timeout_ns;
    t_result     core_result;
    logic        advance;

    // Evaluate the held item when the result register can take it
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign o_cfg_ready   = 1'b1;

    // Capture an accepted transaction into the input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in.opcode            <= s_axis_tuser;
            r_in.enable_value      <= s_axis_tdata[0];
            r_in.frame_epoch       <= s_axis_tdata[32:1];
            r_in.frame_sequence    <= s_axis_tdata[64:33];
            r_in.resync_generation <= s_axis_tdata[96:65];
            r_in.discontinuity     <= s_axis_tdata[97];
            r_in.button_pressed    <= s_axis_tdata[98];
            r_in.receive_ns        <= s_axis_tdata[162:99];
            r_in.now_ns            <= s_axis_tdata[226:163];
        end
    end

    // Hold the timeout register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout_ns <= TIMEOUT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_timeout_ns <= i_cfg_data;
        end
    end

    tfg_core #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (advance),
        .i_item       (r_in),
        .i_timeout_ns (r_timeout_ns),
        .o_result     (core_result)
    );

    // Load the result register, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= core_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out.is_enabled, r_out.is_live, r_out.is_stale,
                            r_out.has_applied, r_out.age_ns, r_out.button_action,
                            r_out.frame_action};

endmodule

### src/tfg_core.sv
// ----------------------------------------------------------------------------
// tfg_core: gate state and single-pass item evaluation
//
// Holds the enable flag, the applied frame reference and the button history.
// Evaluates one item combinationally and updates the state on each step.
// ----------------------------------------------------------------------------
module tfg_core #(
    parameter int unsigned COUNTER_BITS = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_step,
    input  tfg_pkg::t_item  i_item,
    input  logic [62:0]     i_timeout_ns,
    output tfg_pkg::t_result o_result
);
    import tfg_pkg::*;

    // Counter width kept in state: the 32-bit fields reduced to COUNTER_BITS, capped at 32
    localparam int unsigned CW = (COUNTER_BITS < 32) ? COUNTER_BITS : 32;

    // Age of a frame: zero when either time is unknown or the frame is ahead
    function automatic logic [62:0] age_of(input logic [63:0] rx, input logic [63:0] now);
        logic [63:0] diff;
        logic        known;
        diff  = now - rx;
        known = (rx != 64'd0) && !rx[63] && (now != 64'd0) && !now[63];
        if (known && !diff[63] && (diff != 64'd0)) begin
            return diff[62:0];
        end
        return 63'd0;
    endfunction

    logic          r_enabled,        n_enabled;
    logic          r_awaiting,       n_awaiting;
    logic          r_applied_valid,  n_applied_valid;
    logic [CW-1:0] r_applied_epoch,  n_applied_epoch;
    logic [CW-1:0] r_applied_seq,    n_applied_seq;
    logic [CW-1:0] r_applied_resync, n_applied_resync;
    logic [63:0]   r_applied_rx,     n_applied_rx;
    logic          r_button_seen,    n_button_seen;
    logic [CW-1:0] r_button_epoch,   n_button_epoch;
    logic [CW-1:0] r_button_resync,  n_button_resync;
    logic          r_last_button,    n_last_button;

    logic [CW-1:0] epoch;
    logic [CW-1:0] seq;
    logic [CW-1:0] resync;
    logic [63:0]   age_rx;
    logic [62:0]   age;
    logic          age_stale;
    logic          rx_known;
    logic          toggle;
    logic          new_stream;
    t_result       res;

    assign epoch  = i_item.frame_epoch[CW-1:0];
    assign seq    = i_item.frame_sequence[CW-1:0];
    assign resync = i_item.resync_generation[CW-1:0];

    // One age subtractor: freshness uses the applied frame, classify the item
    assign age_rx    = (i_item.opcode == OP_FRESHNESS) ? r_applied_rx : i_item.receive_ns;
    assign age       = age_of(age_rx, i_item.now_ns);
    assign age_stale = (age >= i_timeout_ns);
    assign rx_known  = (i_item.receive_ns != 64'd0) && !i_item.receive_ns[63];
    assign new_stream = !r_button_seen || (epoch != r_button_epoch)
                        || (resync != r_button_resync);

    // Evaluate the item and form the next state
    always_comb begin
        n_enabled        = r_enabled;
        n_awaiting       = r_awaiting;
        n_applied_valid  = r_applied_valid;
        n_applied_epoch  = r_applied_epoch;
        n_applied_seq    = r_applied_seq;
        n_applied_resync = r_applied_resync;
        n_applied_rx     = r_applied_rx;
        n_button_seen    = r_button_seen;
        n_button_epoch   = r_button_epoch;
        n_button_resync  = r_button_resync;
        n_last_button    = r_last_button;
        toggle           = 1'b0;
        res              = '0;

        unique case (i_item.opcode)
            OP_SET_ENABLE: begin
                toggle = (i_item.enable_value != r_enabled);
            end
            OP_BUTTON: begin
                n_button_seen   = 1'b1;
                n_button_epoch  = epoch;
                n_button_resync = resync;
                n_last_button   = i_item.button_pressed;
                if (!new_stream && (r_last_button != i_item.button_pressed)) begin
                    toggle            = 1'b1;
                    res.button_action = r_enabled ? BA_PAUSE : BA_RESUME;
                end
            end
            OP_CLASSIFY: begin
                res.age_ns = age;
                if (!r_enabled) begin
                    res.frame_action = FA_IGNORE_DISABLED;
                end else if (!rx_known || age_stale) begin
                    res.frame_action = FA_IGNORE_STALE;
                end else if (r_applied_valid && ((epoch < r_applied_epoch) ||
                             ((epoch == r_applied_epoch) && (seq <= r_applied_seq)))) begin
                    res.frame_action = FA_IGNORE_APPLIED;
                end else if (!r_applied_valid || (epoch != r_applied_epoch) ||
                             i_item.discontinuity || (resync > r_applied_resync)) begin
                    res.frame_action = FA_RESET_APPLY;
                end else begin
                    res.frame_action = FA_APPLY;
                end
            end
            OP_COMMIT: begin
                n_applied_valid = 1'b1;
                n_applied_epoch = epoch;
                n_applied_seq   = seq;
                if (resync > r_applied_resync) begin
                    n_applied_resync = resync;
                end
                n_applied_rx = i_item.receive_ns;
                n_awaiting   = 1'b0;
            end
            OP_FRESHNESS: begin
                if (r_applied_valid) begin
                    res.age_ns = age;
                end
                if (r_enabled && r_applied_valid) begin
                    res.is_stale = age_stale;
                    res.is_live  = !r_awaiting && !age_stale;
                end
            end
            default: begin
            end
        endcase

        // Flip the enable level; enabling drops the applied reference
        if (toggle) begin
            n_enabled  = !r_enabled;
            n_awaiting = !r_enabled;
            if (!r_enabled) begin
                n_applied_valid  = 1'b0;
                n_applied_epoch  = '0;
                n_applied_seq    = '0;
                n_applied_resync = '0;
                n_applied_rx     = '0;
            end
        end

        res.has_applied = n_applied_valid;
        res.is_enabled  = n_enabled;
    end

    assign o_result = res;

    // Commit the next state on each evaluated transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled        <= 1'b0;
            r_awaiting       <= 1'b0;
            r_applied_valid  <= 1'b0;
            r_applied_epoch  <= '0;
            r_applied_seq    <= '0;
            r_applied_resync <= '0;
            r_applied_rx     <= '0;
            r_button_seen    <= 1'b0;
            r_button_epoch   <= '0;
            r_button_resync  <= '0;
            r_last_button    <= 1'b0;
        end else if (i_step) begin
            r_enabled        <= n_enabled;
            r_awaiting       <= n_awaiting;
            r_applied_valid  <= n_applied_valid;
            r_applied_epoch  <= n_applied_epoch;
            r_applied_seq    <= n_applied_seq;
            r_applied_resync <= n_applied_resync;
            r_applied_rx     <= n_applied_rx;
            r_button_seen    <= n_button_seen;
            r_button_epoch   <= n_button_epoch;
            r_button_resync  <= n_button_resync;
            r_last_button    <= n_last_button;
        end
    end

    // A commit always leaves a valid applied reference
    a_commit_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && (i_item.opcode == OP_COMMIT)) |=> r_applied_valid)
        else $error("applied reference not valid after commit");

    // Set enable leaves the requested level
    a_set_enable_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && (i_item.opcode == OP_SET_ENABLE))
        |=> (r_enabled == $past(i_item.enable_value)))
        else $error("enable level differs from request");

    // A live report needs an enabled gate with a fresh applied frame
    a_live_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && res.is_live) |-> (res.is_enabled && res.has_applied && !res.is_stale))
        else $error("live reported without enabled fresh frame");

    // A pause leaves the gate disabled, a resume enabled and awaiting a frame
    a_button_toggle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && (res.button_action == BA_RESUME)) |=> (r_enabled && r_awaiting
        && !r_applied_valid))
        else $error("resume did not re-arm the gate");

    a_button_pause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && (res.button_action == BA_PAUSE)) |=> (!r_enabled && !r_awaiting))
        else $error("pause did not disable the gate");

endmodule
